// File: design/assert_macros.svh
// Assertion macros used by the checker file of the grid search block.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GNCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GNCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gncs_pkg.sv
// Package of the grid nearest-cell search block: codes, states, widths.
// No dependencies.
`timescale 1ns / 1ps

package gncs_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int NUM_TYPES_DEF  = 4;

  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int COORD_W    = 6;
  localparam int TYPE_W     = 2;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE      = 2'd0,
    OP_READ       = 2'd1,
    OP_NEAR_EMPTY = 2'd2,
    OP_NEAR_TYPE  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_NONE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

endpackage

// File: design/gncs_ram.sv
// Cell store: single-port-write, single-port-read synchronous RAM,
// read data registered in the cycle after the address. No dependencies.
`timescale 1ns / 1ps

module gncs_ram #(
  parameter int WORD_W = 3,
  parameter int DEPTH  = 4096,
  parameter int AW     = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/grid_nearest_cell_search_top.sv
// Grid nearest-cell search: occupancy grid in one RAM with write, read and
// nearest-cell scans. Depends on gncs_pkg and gncs_ram.
`timescale 1ns / 1ps

// One request at a time. After reset the block zeroes the cell RAM, one
// entry per cycle, all MAX_WIDTH * MAX_HEIGHT entries (4096 by default); no
// request is taken during that pass, configuration writes are. A write
// goes through the execute and finish states, an in-bounds read through
// execute, read wait and finish. A nearest search sweeps every cell of the
// width x height area in use through the RAM read port, one cell per cycle,
// then drains the distance pipeline before its result is loaded; the sweep
// is skipped when the width or height is zero. The next request is taken as
// soon as the result sits in the output register, even if it has not yet
// been taken.

module grid_nearest_cell_search_top
  import gncs_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int NUM_TYPES  = NUM_TYPES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x[5:0], pos_y[11:6], write_occupied[12], cell_type[14:13], zero[15]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // found_x[5:0], found_y[11:6], read_occupied[12], read_type[14:13], zero[15]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [ST_W-1:0]       m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XLW    = $clog2(MAX_WIDTH + 1);
  localparam int YLW    = $clog2(MAX_HEIGHT + 1);
  localparam int XYLW   = (XLW > YLW) ? XLW : YLW;
  localparam int LW     = (XYLW > CFG_W) ? XYLW : CFG_W;
  localparam int SQW    = 2 * LW;
  localparam int DW     = SQW + 1;
  localparam int TW     = $clog2(NUM_TYPES);
  localparam int TCW    = TW + TYPE_W;
  localparam int WORD_W = TW + 1;

  localparam logic [LW-1:0]  MAX_W_C  = LW'(MAX_WIDTH);
  localparam logic [LW-1:0]  MAX_H_C  = LW'(MAX_HEIGHT);
  localparam logic [AW:0]    ROW_C    = (AW + 1)'(MAX_WIDTH);
  localparam logic [AW-1:0]  LAST_A_C = AW'(DEPTH - 1);
  localparam logic [TCW-1:0] NT_C     = TCW'(NUM_TYPES);
  localparam logic [TCW-1:0] NT_MAX_C = TCW'(NUM_TYPES - 1);

  state_e state_q, state_d;

  logic [CFG_W-1:0]  gw_q, gh_q;
  logic [AW-1:0]     clr_q;

  op_e               op_q;
  logic [COORD_W-1:0] px_q, py_q;
  logic              wocc_q;
  logic [TYPE_W-1:0] ctype_q;

  logic [LW-1:0]     x_q, y_q, x_d, y_d;

  logic              p1_v_q, p2_v_q;
  logic [LW-1:0]     p1_x_q, p1_y_q, p1_dx_q, p1_dy_q;
  logic              p2_match_q;
  logic [LW-1:0]     p2_x_q, p2_y_q;
  logic [SQW-1:0]    p2_sqx_q, p2_sqy_q;

  logic              have_q;
  logic [DW-1:0]     best_q;
  logic [LW-1:0]     bx_q, by_q;

  status_e           res_st_q, res_st_d;
  logic [COORD_W-1:0] res_fx_q, res_fx_d, res_fy_q, res_fy_d;
  logic              res_occ_q, res_occ_d;
  logic [TYPE_W-1:0] res_typ_q, res_typ_d;

  logic              m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [ST_W-1:0]   m_user_q;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic              issue, scan_start, out_load, in_take;
  logic [LW-1:0]     w_used, h_used, px_l, py_l, dx, dy;
  logic              in_bounds;
  logic [AW-1:0]     cell_addr, scan_addr;
  logic [TCW-1:0]    ctype_ext, rd_type_ext, wtype;
  logic              rd_occ, match;
  logic [DW-1:0]     cand_dist;

  assign w_used = (LW'(gw_q) > MAX_W_C) ? MAX_W_C : LW'(gw_q);
  assign h_used = (LW'(gh_q) > MAX_H_C) ? MAX_H_C : LW'(gh_q);
  assign px_l   = LW'(px_q);
  assign py_l   = LW'(py_q);
  assign in_bounds = (px_l < w_used) && (py_l < h_used);

  assign cell_addr = AW'((AW + 1)'(py_l) * ROW_C + (AW + 1)'(px_l));
  assign scan_addr = AW'((AW + 1)'(y_q) * ROW_C + (AW + 1)'(x_q));

  assign ctype_ext   = TCW'(ctype_q);
  assign wtype       = (ctype_ext >= NT_C) ? NT_MAX_C : ctype_ext;
  assign rd_occ      = mem_rdata[TW];
  assign rd_type_ext = TCW'(mem_rdata[TW-1:0]);
  assign match       = (op_q == OP_NEAR_EMPTY) ? !rd_occ
                                               : (rd_occ && (rd_type_ext == ctype_ext));

  assign dx   = (x_q > px_l) ? (x_q - px_l) : (px_l - x_q);
  assign dy   = (y_q > py_l) ? (y_q - py_l) : (py_l - y_q);
  assign cand_dist = DW'(p2_sqx_q) + DW'(p2_sqy_q);

  assign in_take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = cell_addr;
    issue      = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    s_axis_tready = 1'b0;
    x_d        = x_q;
    y_d        = y_q;
    res_st_d   = res_st_q;
    res_fx_d   = res_fx_q;
    res_fy_d   = res_fy_q;
    res_occ_d  = res_occ_q;
    res_typ_d  = res_typ_q;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_q == LAST_A_C) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_st_d  = ST_OK;
        res_fx_d  = '0;
        res_fy_d  = '0;
        res_occ_d = 1'b0;
        res_typ_d = '0;
        case (op_q)
          OP_WRITE: begin
            if (in_bounds) begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr;
              mem_wdata = {wocc_q, wocc_q ? wtype[TW-1:0] : TW'(0)};
            end else begin
              res_st_d = ST_BOUNDS;
            end
            state_d = S_FINISH;
          end
          OP_READ: begin
            if (in_bounds) begin
              mem_re  = 1'b1;
              state_d = S_RDWAIT;
            end else begin
              res_st_d = ST_BOUNDS;
              state_d  = S_FINISH;
            end
          end
          default: begin
            scan_start = 1'b1;
            x_d = '0;
            y_d = '0;
            if ((w_used == '0) || (h_used == '0)) begin
              state_d = S_DRAIN;
            end else begin
              state_d = S_SCAN;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        res_occ_d = rd_occ;
        res_typ_d = TYPE_W'(rd_type_ext);
        state_d   = S_FINISH;
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_addr;
        issue     = 1'b1;
        if (x_q == w_used - LW'(1)) begin
          x_d = '0;
          if (y_q == h_used - LW'(1)) begin
            state_d = S_DRAIN;
          end else begin
            y_d = y_q + LW'(1);
          end
        end else begin
          x_d = x_q + LW'(1);
        end
      end
      S_DRAIN: begin
        if (!p1_v_q && !p2_v_q) begin
          if (have_q) begin
            res_st_d = ST_OK;
            res_fx_d = COORD_W'(bx_q);
            res_fy_d = COORD_W'(by_q);
            if (op_q == OP_NEAR_TYPE) begin
              res_occ_d = 1'b1;
              res_typ_d = ctype_q;
            end
          end else begin
            res_st_d = ST_NONE;
          end
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      gw_q      <= CFG_DIM_RESET;
      gh_q      <= CFG_DIM_RESET;
      p1_v_q    <= 1'b0;
      p2_v_q    <= 1'b0;
      have_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_valid_i) begin
        if (cfg_addr_i == REG_GRID_WIDTH) begin
          gw_q <= cfg_data_i;
        end else begin
          gh_q <= cfg_data_i;
        end
      end
      p1_v_q <= issue;
      p2_v_q <= p1_v_q;
      if (scan_start) begin
        have_q <= 1'b0;
      end else if (p2_v_q && p2_match_q && (!have_q || (cand_dist < best_q))) begin
        have_q <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= op_e'(s_axis_tuser);
      px_q    <= s_axis_tdata[5:0];
      py_q    <= s_axis_tdata[11:6];
      wocc_q  <= s_axis_tdata[12];
      ctype_q <= s_axis_tdata[14:13];
    end
    x_q <= x_d;
    y_q <= y_d;
    p1_x_q  <= x_q;
    p1_y_q  <= y_q;
    p1_dx_q <= dx;
    p1_dy_q <= dy;
    p2_match_q <= match;
    p2_x_q     <= p1_x_q;
    p2_y_q     <= p1_y_q;
    p2_sqx_q   <= SQW'(p1_dx_q) * SQW'(p1_dx_q);
    p2_sqy_q   <= SQW'(p1_dy_q) * SQW'(p1_dy_q);
    if (p2_v_q && p2_match_q && (!have_q || (cand_dist < best_q))) begin
      best_q <= cand_dist;
      bx_q   <= p2_x_q;
      by_q   <= p2_y_q;
    end
    res_st_q  <= res_st_d;
    res_fx_q  <= res_fx_d;
    res_fy_q  <= res_fy_d;
    res_occ_q <= res_occ_d;
    res_typ_q <= res_typ_d;
    if (out_load) begin
      m_data_q <= {1'b0, res_typ_q, res_occ_q, res_fy_q, res_fx_q};
      m_user_q <= res_st_q;
    end
  end

  gncs_ram #(
    .WORD_W(WORD_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: design/gncs_checker.sv
// Port-level checks of the grid search block, bound to the top level.
// Depends on gncs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gncs_checker
  import gncs_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [ST_W-1:0]       m_axis_tuser
);

  `GNCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `GNCS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in work")
  `GNCS_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == ST_OK || m_axis_tuser == ST_BOUNDS || m_axis_tuser == ST_NONE, "undefined status")
  `GNCS_ASSERT_NOW(a_fail_zero, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0, "fields not zero on failure")

endmodule

bind grid_nearest_cell_search_top gncs_checker u_checker (.*);
